// ----- hw/rtl/dss_pkg.sv -----
// Shared types and constants for the drum step sequencer.
// Holds field widths, register indexes, reset values and the
// command and status structs between the controller and the datapath.
package dss_pkg;

    localparam int unsigned INSTRUMENTS_DEF = 3;
    localparam int unsigned STEPS_DEF       = 16;

    localparam int unsigned SPS_W       = 20;
    localparam int unsigned SPB_W       = 22;
    localparam int unsigned FRAME_W     = 22;
    localparam int unsigned NOTE_W      = 7;
    localparam int unsigned VEL_W       = 7;
    localparam int unsigned CELL_IDX_W  = 6;
    localparam int unsigned CELL_W      = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_SPS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE2 = 3'd4;

    localparam logic [SPS_W-1:0]  SPS_RESET   = 20'd5512;
    localparam logic [SPB_W-1:0]  SPB_RESET   = 22'd22050;
    localparam logic [NOTE_W-1:0] NOTE0_RESET = 7'd36;
    localparam logic [NOTE_W-1:0] NOTE1_RESET = 7'd38;
    localparam logic [NOTE_W-1:0] NOTE2_RESET = 7'd42;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CELL = 1'b1;
    localparam logic KIND_OFF  = 1'b0;
    localparam logic KIND_ON   = 1'b1;

    typedef struct packed {
        logic capture;
        logic cell_wr;
        logic set_run;
        logic clr_pos;
        logic clr_sound;
        logic load_pos;
        logic div_start;
        logic emit_off;
        logic emit_on;
        logic step_adv;
        logic frame_adv;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic playing;
        logic pos_valid;
        logic resync;
        logic was_running;
        logic phase_ok;
        logic div_done;
        logic phase_zero;
        logic sounding_cur;
        logic cell_on;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
    } t_sts;

endpackage

// ----- hw/rtl/drum_step_sequencer.sv -----
// Drum step sequencer top level joining dss_ctrl and dss_datapath; depends on dss_pkg.
// A cell write is taken while idle. A frame tick visits read, note-off and note-on steps per
// instrument on a step boundary, and read and note-off steps per instrument on a stop.
// The remainder unit runs after a resync or a sixteenth-length write, and
// events wait for the output register to drain. Synchronous active-low reset restores the
// register defaults and clears transport state; the pattern memory is not cleared.
module drum_step_sequencer #(
    parameter int unsigned INSTRUMENTS = dss_pkg::INSTRUMENTS_DEF,
    parameter int unsigned STEPS       = dss_pkg::STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic                           i_playing,
    input  logic                           i_position_valid,
    input  logic                           i_resync,
    input  logic [dss_pkg::FRAME_W-1:0]    i_position_frame,
    input  logic [dss_pkg::CELL_IDX_W-1:0] i_cell_index,
    input  logic [dss_pkg::CELL_W-1:0]     i_cell_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_note_kind,
    output logic [dss_pkg::NOTE_W-1:0]     o_note_number,
    output logic [dss_pkg::VEL_W-1:0]      o_velocity,
    output logic                           o_last
);

    localparam int unsigned IW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

    dss_pkg::t_cmd cmd;
    dss_pkg::t_sts sts;
    logic [IW-1:0] inst;

    assign o_cfg_ready = 1'b1;

    dss_ctrl #(
        .INSTRUMENTS (INSTRUMENTS),
        .IW          (IW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_inst  (inst)
    );

    dss_datapath #(
        .INSTRUMENTS (INSTRUMENTS),
        .STEPS       (STEPS),
        .IW          (IW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_playing        (i_playing),
        .i_position_valid (i_position_valid),
        .i_resync         (i_resync),
        .i_position_frame (i_position_frame),
        .i_cell_index     (i_cell_index),
        .i_cell_value     (i_cell_value),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_note_kind      (o_note_kind),
        .o_note_number    (o_note_number),
        .o_velocity       (o_velocity),
        .o_last           (o_last),
        .i_cmd            (cmd),
        .i_inst           (inst),
        .o_sts            (sts)
    );

endmodule

// ----- hw/rtl/dss_mod.sv -----
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Used by the datapath to find the frame phase within a sixteenth.
// Depends on nothing but its parameters.
module dss_mod #(
    parameter int unsigned DIVIDEND_W = 22,
    parameter int unsigned DIVISOR_W  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam int unsigned CW = $clog2(DIVIDEND_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic [CW-1:0]         r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, i_divisor};
        if (shifted >= {1'b0, i_divisor}) begin
            n_rem = diff[DIVISOR_W-1:0];
        end else begin
            n_rem = shifted[DIVISOR_W-1:0];
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_LAST);
    assign o_rem  = n_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

endmodule

// ----- hw/rtl/dss_ctrl.sv -----
// Controller state machine of the drum step sequencer.
// Walks a tick through its decision step and, as needed, its phase, instrument and flush steps.
// Depends on dss_pkg for the command and status structs.
module dss_ctrl #(
    parameter int unsigned INSTRUMENTS = dss_pkg::INSTRUMENTS_DEF,
    parameter int unsigned IW          = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    output logic          o_stall,
    input  dss_pkg::t_sts i_sts,
    output dss_pkg::t_cmd o_cmd,
    output logic [IW-1:0] o_inst
);

    localparam logic [IW-1:0] INST_LAST = IW'(INSTRUMENTS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TICK  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_OFF   = 4'd5;
    localparam logic [3:0] S_ON    = 4'd6;
    localparam logic [3:0] S_ADV   = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [IW-1:0] r_inst;
    logic [IW-1:0] n_inst;
    logic          r_stop_mode;
    logic          n_stop_mode;

    assign o_stall = (r_state != S_IDLE);
    assign o_inst  = r_inst;

    always_comb begin
        n_state     = r_state;
        n_inst      = r_inst;
        n_stop_mode = r_stop_mode;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == dss_pkg::FUNC_CELL) begin
                        o_cmd.cell_wr = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_TICK;
                    end
                end
            end
            S_TICK: begin
                o_cmd.set_run = 1'b1;
                n_inst        = '0;
                if (!i_sts.playing) begin
                    if (i_sts.was_running) begin
                        o_cmd.clr_pos = 1'b1;
                        n_stop_mode   = 1'b1;
                        n_state       = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!i_sts.pos_valid) begin
                    o_cmd.clr_pos   = 1'b1;
                    o_cmd.clr_sound = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.resync || !i_sts.phase_ok) begin
                    o_cmd.load_pos  = i_sts.resync;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_stop_mode = 1'b0;
                n_inst      = '0;
                n_state     = i_sts.phase_zero ? S_RD : S_ADV;
            end
            S_RD: begin
                n_state = S_OFF;
            end
            S_OFF: begin
                if (!i_sts.sounding_cur || i_sts.emit_ok) begin
                    o_cmd.emit_off = i_sts.sounding_cur;
                    if (!r_stop_mode) begin
                        n_state = S_ON;
                    end else if (r_inst == INST_LAST) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_inst  = r_inst + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_ON: begin
                if (!i_sts.cell_on || i_sts.emit_ok) begin
                    o_cmd.emit_on = i_sts.cell_on;
                    if (r_inst == INST_LAST) begin
                        o_cmd.step_adv = 1'b1;
                        n_state        = S_ADV;
                    end else begin
                        n_inst  = r_inst + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_ADV: begin
                o_cmd.frame_adv = 1'b1;
                n_state         = S_FLUSH;
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inst      <= '0;
            r_stop_mode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inst      <= n_inst;
            r_stop_mode <= n_stop_mode;
        end
    end

endmodule

// ----- hw/rtl/dss_datapath.sv -----
// Datapath of the drum step sequencer: configuration, pattern memory,
// transport counters, sounding flags, event buffer and output register.
// Depends on dss_pkg and on dss_mod for the frame phase.
module dss_datapath #(
    parameter int unsigned INSTRUMENTS = dss_pkg::INSTRUMENTS_DEF,
    parameter int unsigned STEPS       = dss_pkg::STEPS_DEF,
    parameter int unsigned IW          = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [dss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_playing,
    input  logic                             i_position_valid,
    input  logic                             i_resync,
    input  logic [dss_pkg::FRAME_W-1:0]      i_position_frame,
    input  logic [dss_pkg::CELL_IDX_W-1:0]   i_cell_index,
    input  logic [dss_pkg::CELL_W-1:0]       i_cell_value,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_note_kind,
    output logic [dss_pkg::NOTE_W-1:0]       o_note_number,
    output logic [dss_pkg::VEL_W-1:0]        o_velocity,
    output logic                             o_last,
    input  dss_pkg::t_cmd                    i_cmd,
    input  logic [IW-1:0]                    i_inst,
    output dss_pkg::t_sts                    o_sts
);

    localparam int unsigned DEPTH = INSTRUMENTS * STEPS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = $clog2(STEPS);
    localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);

    logic [dss_pkg::SPS_W-1:0]   r_sps;
    logic [dss_pkg::SPB_W-1:0]   r_spb;
    logic [dss_pkg::NOTE_W-1:0]  r_note0;
    logic [dss_pkg::NOTE_W-1:0]  r_note1;
    logic [dss_pkg::NOTE_W-1:0]  r_note2;

    logic [dss_pkg::FRAME_W-1:0] r_frame;
    logic [SW-1:0]               r_step;
    logic [dss_pkg::SPS_W-1:0]   r_phase;
    logic                        r_phase_ok;
    logic [INSTRUMENTS-1:0]      r_sounding;
    logic                        r_was_running;

    logic                        r_playing;
    logic                        r_pos_valid;
    logic                        r_resync;
    logic [dss_pkg::FRAME_W-1:0] r_pos;

    logic [dss_pkg::CELL_W-1:0]  r_mem [DEPTH];
    logic [dss_pkg::CELL_W-1:0]  r_cell;

    logic                        r_pend_valid;
    logic                        r_pend_kind;
    logic [dss_pkg::NOTE_W-1:0]  r_pend_note;
    logic [dss_pkg::VEL_W-1:0]   r_pend_vel;

    logic                        r_o_valid;
    logic                        r_o_kind;
    logic [dss_pkg::NOTE_W-1:0]  r_o_note;
    logic [dss_pkg::VEL_W-1:0]   r_o_vel;
    logic                        r_o_last;

    logic [dss_pkg::SPS_W-1:0]   sps_eff;
    logic [dss_pkg::SPB_W-1:0]   spb_eff;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        wr_en;
    logic                        cell_on;
    logic [dss_pkg::NOTE_W-1:0]  note_cur;
    logic                        emit;
    logic                        ev_kind;
    logic [dss_pkg::VEL_W-1:0]   ev_vel;
    logic                        out_free;
    logic                        push_out;
    logic [dss_pkg::FRAME_W:0]   frame_inc;
    logic                        frame_wrap;
    logic [dss_pkg::SPS_W:0]     phase_inc;
    logic                        phase_wrap;
    logic [dss_pkg::FRAME_W-1:0] div_dividend;
    logic                        div_done;
    logic [dss_pkg::SPS_W-1:0]   div_rem;

    assign sps_eff = (r_sps == '0) ? dss_pkg::SPS_W'(1) : r_sps;
    assign spb_eff = (r_spb == '0) ? dss_pkg::SPB_W'(1) : r_spb;

    assign rd_addr = AW'(32'(i_inst) * 32'(STEPS) + 32'(r_step));
    assign wr_addr = AW'(i_cell_index);
    assign wr_en   = i_cmd.cell_wr && (32'(i_cell_index) < 32'(DEPTH));

    assign cell_on = !r_cell[dss_pkg::CELL_W-1] && (r_cell[dss_pkg::VEL_W-1:0] != '0);

    always_comb begin
        if (i_inst == IW'(0)) begin
            note_cur = r_note0;
        end else if (i_inst == IW'(1)) begin
            note_cur = r_note1;
        end else begin
            note_cur = r_note2;
        end
    end

    assign emit     = i_cmd.emit_off || i_cmd.emit_on;
    assign ev_kind  = i_cmd.emit_on ? dss_pkg::KIND_ON : dss_pkg::KIND_OFF;
    assign ev_vel   = i_cmd.emit_on ? r_cell[dss_pkg::VEL_W-1:0] : '0;
    assign out_free = !r_o_valid || !i_stall;
    assign push_out = (emit && r_pend_valid) || i_cmd.flush;

    assign frame_inc  = {1'b0, r_frame} + 1'b1;
    assign frame_wrap = frame_inc >= {1'b0, spb_eff};
    assign phase_inc  = {1'b0, r_phase} + 1'b1;
    assign phase_wrap = phase_inc == {1'b0, sps_eff};

    assign div_dividend = r_resync ? r_pos : r_frame;

    dss_mod #(
        .DIVIDEND_W (dss_pkg::FRAME_W),
        .DIVISOR_W  (dss_pkg::SPS_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (sps_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps         <= dss_pkg::SPS_RESET;
            r_spb         <= dss_pkg::SPB_RESET;
            r_note0       <= dss_pkg::NOTE0_RESET;
            r_note1       <= dss_pkg::NOTE1_RESET;
            r_note2       <= dss_pkg::NOTE2_RESET;
            r_frame       <= '0;
            r_step        <= '0;
            r_phase       <= '0;
            r_phase_ok    <= 1'b1;
            r_sounding    <= '0;
            r_was_running <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dss_pkg::CFG_SPS: begin
                        r_sps      <= i_cfg_data[dss_pkg::SPS_W-1:0];
                        r_phase_ok <= 1'b0;
                    end
                    dss_pkg::CFG_SPB: begin
                        r_spb <= i_cfg_data[dss_pkg::SPB_W-1:0];
                    end
                    dss_pkg::CFG_NOTE0: begin
                        r_note0 <= i_cfg_data[dss_pkg::NOTE_W-1:0];
                    end
                    dss_pkg::CFG_NOTE1: begin
                        r_note1 <= i_cfg_data[dss_pkg::NOTE_W-1:0];
                    end
                    dss_pkg::CFG_NOTE2: begin
                        r_note2 <= i_cfg_data[dss_pkg::NOTE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.set_run) begin
                r_was_running <= r_playing;
            end

            if (i_cmd.clr_pos) begin
                r_frame    <= '0;
                r_step     <= '0;
                r_phase    <= '0;
                r_phase_ok <= 1'b1;
            end else if (i_cmd.load_pos) begin
                r_frame    <= r_pos;
                r_phase_ok <= 1'b0;
            end else if (div_done) begin
                r_phase    <= div_rem;
                r_phase_ok <= 1'b1;
            end else if (i_cmd.frame_adv) begin
                if (frame_wrap) begin
                    r_frame <= '0;
                    r_phase <= '0;
                end else begin
                    r_frame <= frame_inc[dss_pkg::FRAME_W-1:0];
                    r_phase <= phase_wrap ? '0 : phase_inc[dss_pkg::SPS_W-1:0];
                end
            end

            if (i_cmd.step_adv) begin
                r_step <= (r_step == STEP_LAST) ? '0 : r_step + 1'b1;
            end

            if (i_cmd.clr_sound) begin
                r_sounding <= '0;
            end else if (i_cmd.emit_off) begin
                r_sounding[i_inst] <= 1'b0;
            end else if (i_cmd.emit_on) begin
                r_sounding[i_inst] <= 1'b1;
            end

            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end

            if (push_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_playing   <= i_playing;
            r_pos_valid <= i_position_valid;
            r_resync    <= i_resync;
            r_pos       <= i_position_frame;
        end
        if (wr_en) begin
            r_mem[wr_addr] <= i_cell_value;
        end
        r_cell <= r_mem[rd_addr];
        if (emit) begin
            r_pend_kind <= ev_kind;
            r_pend_note <= note_cur;
            r_pend_vel  <= ev_vel;
        end
        if (push_out) begin
            r_o_kind <= r_pend_kind;
            r_o_note <= r_pend_note;
            r_o_vel  <= r_pend_vel;
            r_o_last <= i_cmd.flush;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_note_kind   = r_o_kind;
    assign o_note_number = r_o_note;
    assign o_velocity    = r_o_vel;
    assign o_last        = r_o_last;

    always_comb begin
        o_sts              = '0;
        o_sts.playing      = r_playing;
        o_sts.pos_valid    = r_pos_valid;
        o_sts.resync       = r_resync;
        o_sts.was_running  = r_was_running;
        o_sts.phase_ok     = r_phase_ok;
        o_sts.div_done     = div_done;
        o_sts.phase_zero   = (r_phase == '0);
        o_sts.sounding_cur = r_sounding[i_inst];
        o_sts.cell_on      = cell_on;
        o_sts.emit_ok      = !r_pend_valid || out_free;
        o_sts.out_free     = out_free;
        o_sts.pend_valid   = r_pend_valid;
    end

endmodule

// ----- tb/tb_drum_step_sequencer.sv -----
// Self-checking testbench for drum_step_sequencer: cell writes and frame ticks in,
// note events out, compared against an in-bench sequencer model under random flow control.
// Depends on dss_pkg and the drum_step_sequencer RTL.
module tb_drum_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CELLS           = dss_pkg::INSTRUMENTS_DEF * dss_pkg::STEPS_DEF;
    localparam int unsigned MAX_EVTS        = 2 * dss_pkg::INSTRUMENTS_DEF;
    localparam int unsigned DIR_ROWS        = 23;
    localparam int unsigned RAND_PHASES     = 7;
    localparam int unsigned ITEMS_PER_PHASE = 20;
    localparam int unsigned SETTLE_CYCLES   = 64;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned NUM_REGS        = 5;

    localparam logic F_CELL = dss_pkg::FUNC_CELL;
    localparam logic F_TICK = dss_pkg::FUNC_TICK;
    localparam logic K_OFF  = dss_pkg::KIND_OFF;
    localparam logic K_ON   = dss_pkg::KIND_ON;

    localparam logic [1:0] EXP_NONE  = 2'd0;
    localparam logic [1:0] EXP_ONE   = 2'd1;
    localparam logic [1:0] EXP_MODEL = 2'd3;

    localparam logic [dss_pkg::CFG_IDX_W-1:0] REG_ORDER [0:NUM_REGS-1] =
        '{dss_pkg::CFG_SPS, dss_pkg::CFG_SPB, dss_pkg::CFG_NOTE0, dss_pkg::CFG_NOTE1,
          dss_pkg::CFG_NOTE2};

    typedef struct packed {
        logic                           func;
        logic                           playing;
        logic                           pos_valid;
        logic                           resync;
        logic [dss_pkg::FRAME_W-1:0]    pos;
        logic [dss_pkg::CELL_IDX_W-1:0] cidx;
        logic [dss_pkg::CELL_W-1:0]     cval;
    } t_frame_item;

    typedef struct packed {
        logic                           func;
        logic                           playing;
        logic                           pos_valid;
        logic                           resync;
        logic [dss_pkg::FRAME_W-1:0]    pos;
        logic [dss_pkg::CELL_IDX_W-1:0] cidx;
        logic [dss_pkg::CELL_W-1:0]     cval;
        logic [1:0]                     exp_mode;
        logic                           exp_kind;
        logic [dss_pkg::NOTE_W-1:0]     exp_note;
        logic [dss_pkg::VEL_W-1:0]      exp_vel;
    } t_dir_row;

    typedef struct packed {
        logic                       kind;
        logic [dss_pkg::NOTE_W-1:0] note;
        logic [dss_pkg::VEL_W-1:0]  vel;
        logic                       last;
    } t_note_evt;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           i_cfg_valid      = 1'b0;
    logic                           o_cfg_ready;
    logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                           i_valid          = 1'b0;
    logic                           o_stall;
    logic                           i_func           = 1'b0;
    logic                           i_playing        = 1'b0;
    logic                           i_position_valid = 1'b0;
    logic                           i_resync         = 1'b0;
    logic [dss_pkg::FRAME_W-1:0]    i_position_frame = '0;
    logic [dss_pkg::CELL_IDX_W-1:0] i_cell_index     = '0;
    logic [dss_pkg::CELL_W-1:0]     i_cell_value     = '0;
    logic                           o_valid;
    logic                           i_stall          = 1'b0;
    logic                           o_note_kind;
    logic [dss_pkg::NOTE_W-1:0]     o_note_number;
    logic [dss_pkg::VEL_W-1:0]      o_velocity;
    logic                           o_last;

    drum_step_sequencer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_playing        (i_playing),
        .i_position_valid (i_position_valid),
        .i_resync         (i_resync),
        .i_position_frame (i_position_frame),
        .i_cell_index     (i_cell_index),
        .i_cell_value     (i_cell_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_note_kind      (o_note_kind),
        .o_note_number    (o_note_number),
        .o_velocity       (o_velocity),
        .o_last           (o_last)
    );

    logic [dss_pkg::CELL_W-1:0] grid [0:CELLS-1];
    logic                       ringing [0:dss_pkg::INSTRUMENTS_DEF-1];
    int unsigned                frm;
    int unsigned                stp;
    logic                       was_run;
    int unsigned                cfg_sps;
    int unsigned                cfg_spb;
    logic [dss_pkg::NOTE_W-1:0] cfg_note [0:dss_pkg::INSTRUMENTS_DEF-1];

    t_note_evt step_evts [0:MAX_EVTS-1];
    int        step_n;
    t_note_evt midi_expect_q [$];

    int unsigned frames_sent   = 0;
    int unsigned events_seen   = 0;
    int unsigned settings_run  = 0;
    int unsigned errors        = 0;
    int unsigned hold_requests = 0;
    logic        calm          = 1'b0;

    function automatic void expect_evt(input t_note_evt e);
        midi_expect_q.insert(midi_expect_q.size(), e);
    endfunction

    function automatic void add_evt(input logic kind, input int unsigned inst,
                                    input logic [dss_pkg::VEL_W-1:0] vel);
        step_evts[step_n] = '{kind, cfg_note[inst > 2 ? 2 : inst], vel, 1'b0};
        step_n++;
    endfunction

    function automatic void predict_midi(input t_frame_item it);
        int unsigned sps;
        int unsigned spb;
        int unsigned k;
        logic [dss_pkg::CELL_W-1:0] v;
        step_n = 0;
        sps = (cfg_sps == 0) ? 1 : cfg_sps;
        spb = (cfg_spb == 0) ? 1 : cfg_spb;
        if (it.func == F_CELL) begin
            if (it.cidx < CELLS) grid[it.cidx] = it.cval;
            return;
        end
        if (!it.playing && was_run) begin
            frm = 0;
            stp = 0;
            for (k = 0; k < dss_pkg::INSTRUMENTS_DEF; k++) begin
                if (ringing[k]) begin
                    ringing[k] = 1'b0;
                    add_evt(K_OFF, k, '0);
                end
            end
        end
        was_run = it.playing;
        if (!it.playing) return;
        if (!it.pos_valid) begin
            frm = 0;
            stp = 0;
            for (k = 0; k < dss_pkg::INSTRUMENTS_DEF; k++) ringing[k] = 1'b0;
            return;
        end
        if (it.resync) frm = it.pos;
        if (frm % sps == 0) begin
            for (k = 0; k < dss_pkg::INSTRUMENTS_DEF; k++) begin
                v = grid[k * dss_pkg::STEPS_DEF + stp];
                if (ringing[k]) begin
                    ringing[k] = 1'b0;
                    add_evt(K_OFF, k, '0);
                end
                if (v >= 1 && v <= 127) begin
                    ringing[k] = 1'b1;
                    add_evt(K_ON, k, v[dss_pkg::VEL_W-1:0]);
                end
            end
            stp = (stp + 1) % dss_pkg::STEPS_DEF;
        end
        if (frm + 1 >= spb) frm = 0;
        else frm = frm + 1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_frame_item random_frame();
        t_frame_item it;
        int unsigned r;
        it.func      = F_TICK;
        it.playing   = 1'b1;
        it.pos_valid = ($urandom_range(0, 99) >= 5);
        it.resync    = ($urandom_range(0, 9) == 0);
        it.pos       = dss_pkg::FRAME_W'($urandom);
        it.cidx      = dss_pkg::CELL_IDX_W'($urandom);
        it.cval      = dss_pkg::CELL_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it.func = F_CELL;
            if ($urandom_range(0, 9) == 0) begin
                it.cidx = dss_pkg::CELL_IDX_W'($urandom_range(CELLS, 63));
            end else begin
                it.cidx = dss_pkg::CELL_IDX_W'($urandom_range(0, CELLS - 1));
            end
            case ($urandom_range(0, 2))
                0: it.cval = '0;
                1: it.cval = dss_pkg::CELL_W'($urandom_range(1, 127));
                default: it.cval = dss_pkg::CELL_W'($urandom_range(128, 255));
            endcase
        end else if (r < 27) begin
            it.playing = 1'b0;
        end
        if (it.resync && $urandom_range(0, 1) == 1) begin
            it.pos = dss_pkg::FRAME_W'(cfg_sps * $urandom_range(0, 4));
        end
        return it;
    endfunction

    task automatic send_frame(input t_frame_item it, input logic use_model);
        int unsigned gap;
        int k;
        t_note_evt e;
        gap = pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= it.func;
        i_playing        <= it.playing;
        i_position_valid <= it.pos_valid;
        i_resync         <= it.resync;
        i_position_frame <= it.pos;
        i_cell_index     <= it.cidx;
        i_cell_value     <= it.cval;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        frames_sent++;
        predict_midi(it);
        if (use_model) begin
            for (k = 0; k < step_n; k++) begin
                e = step_evts[k];
                e.last = (k == step_n - 1);
                expect_evt(e);
            end
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (midi_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned sps, input int unsigned spb,
                              input int unsigned n0, input int unsigned n1,
                              input int unsigned n2);
        int unsigned vals [0:NUM_REGS-1];
        int k;
        vals = '{sps, spb, n0, n1, n2};
        for (k = 0; k < NUM_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[k];
            i_cfg_data  <= dss_pkg::CFG_DATA_W'(vals[k]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (REG_ORDER[k])
                dss_pkg::CFG_SPS:   cfg_sps     = vals[k] & ((1 << dss_pkg::SPS_W) - 1);
                dss_pkg::CFG_SPB:   cfg_spb     = vals[k] & ((1 << dss_pkg::SPB_W) - 1);
                dss_pkg::CFG_NOTE0: cfg_note[0] = dss_pkg::NOTE_W'(vals[k]);
                dss_pkg::CFG_NOTE1: cfg_note[1] = dss_pkg::NOTE_W'(vals[k]);
                dss_pkg::CFG_NOTE2: cfg_note[2] = dss_pkg::NOTE_W'(vals[k]);
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : receiver
        int unsigned len;
        int unsigned holds_done;
        holds_done = 0;
        forever begin
            if (hold_requests != holds_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                i_stall <= 1'b0;
                len = $urandom_range(1, 8);
                repeat (len) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (len) @(posedge i_clk);
            end
        end
    end

    initial begin : note_monitor
        t_note_evt want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                events_seen++;
                if (midi_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: unexpected event kind %0d note %0d vel %0d last %0d",
                                 o_note_kind, o_note_number, o_velocity, o_last);
                    end
                end else begin
                    want = midi_expect_q.pop_front();
                    if (o_note_kind !== want.kind || o_note_number !== want.note ||
                        o_velocity !== want.vel || o_last !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("mismatch: expected kind %0d note %0d vel %0d last %0d, %s",
                                     want.kind, want.note, want.vel, want.last, "got");
                            $display("          kind %0d note %0d vel %0d last %0d",
                                     o_note_kind, o_note_number, o_velocity, o_last);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb_drum_step_sequencer: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    rows [0:DIR_ROWS-1];
        t_frame_item it;
        int unsigned p;
        int unsigned i;
        int unsigned sps;
        int unsigned spb;
        int unsigned n0;
        int unsigned n1;
        int unsigned n2;

        rows = '{
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd0,  8'd127, EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd16, 8'd1,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd32, 8'd128, EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b1, 1'b1, 1'b1, 22'h3FFFFF, 6'd63, 8'd255, EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd48, 8'd5,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd1,  8'd255, EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd17, 8'd64,  EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd33, 8'd127, EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b1, 22'd5512,   6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b1, 22'd22049,  6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b1, 22'h3FFFFF, 6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b0, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b0, 1'b0, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b0, 1'b1, 1'b1, 22'h3FFFFF, 6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b0, 1'b0, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0},
            '{F_CELL, 1'b0, 1'b0, 1'b0, 22'd0,      6'd16, 8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b1, 1'b1, 1'b1, 22'd0,      6'd0,  8'd0,   EXP_ONE,   K_ON,
              dss_pkg::NOTE0_RESET, 7'd127},
            '{F_TICK, 1'b1, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_NONE,  K_OFF, 7'd0, 7'd0},
            '{F_TICK, 1'b0, 1'b1, 1'b0, 22'd0,      6'd0,  8'd0,   EXP_MODEL, K_OFF, 7'd0, 7'd0}
        };

        cfg_sps     = dss_pkg::SPS_RESET;
        cfg_spb     = dss_pkg::SPB_RESET;
        cfg_note[0] = dss_pkg::NOTE0_RESET;
        cfg_note[1] = dss_pkg::NOTE1_RESET;
        cfg_note[2] = dss_pkg::NOTE2_RESET;
        for (i = 0; i < dss_pkg::INSTRUMENTS_DEF; i++) ringing[i] = 1'b0;
        frm     = 0;
        stp     = 0;
        was_run = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The pattern memory powers up undefined, so every cell is cleared before any tick.
        for (i = 0; i < CELLS; i++) begin
            it      = '0;
            it.func = F_CELL;
            it.cidx = dss_pkg::CELL_IDX_W'(i);
            send_frame(it, 1'b1);
        end

        for (i = 0; i < DIR_ROWS; i++) begin
            it = '{rows[i].func, rows[i].playing, rows[i].pos_valid, rows[i].resync,
                   rows[i].pos, rows[i].cidx, rows[i].cval};
            send_frame(it, rows[i].exp_mode == EXP_MODEL);
            if (rows[i].exp_mode == EXP_ONE) begin
                expect_evt('{rows[i].exp_kind, rows[i].exp_note, rows[i].exp_vel, 1'b1});
            end
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            settle();
            n0 = $urandom_range(0, 127);
            n1 = $urandom_range(0, 127);
            n2 = $urandom_range(0, 127);
            case (p)
                0: begin
                    sps = 1;
                    spb = 1;
                    n0  = 0;
                    n1  = 127;
                end
                1: begin
                    sps = 0;
                    spb = 0;
                end
                2: begin
                    sps = (1 << dss_pkg::SPS_W) - 1;
                    spb = (1 << dss_pkg::SPB_W) - 1;
                    n0  = 127;
                    n1  = 0;
                end
                default: begin
                    sps = $urandom_range(2, 4);
                    spb = $urandom_range(4, 48);
                end
            endcase
            set_config(sps, spb, n0, n1, n2);
            calm = (p == 5);
            if (p == 4) hold_requests++;
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                it = random_frame();
                send_frame(it, 1'b1);
            end
        end

        i_valid <= 1'b0;
        while (midi_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers and %0d note event transfers over %0d settings",
                 frames_sent, events_seen, settings_run + 1);
        $display("including stops, invalid positions, resyncs and a long output hold; %0d %s",
                 errors, "mismatches");
        if (errors == 0) begin
            $display("tb_drum_step_sequencer: done, clean");
        end else begin
            $display("tb_drum_step_sequencer: done, errors");
        end
        $finish;
    end

endmodule
